### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define FDNAM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define FDNAM_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hw/rtl/fdnam_pkg.sv
// ----------------------------------------------------------------------------
// fdnam_pkg
// Types, constants and table functions of the decimating FIR noise/AM mixer.
// ----------------------------------------------------------------------------
package fdnam_pkg;

    // Default structural parameters
    localparam int DEF_TAPS            = 31;
    localparam int DEF_DECIMATION      = 8;
    localparam int DEF_SINE_TABLE_BITS = 8;

    localparam int SAMPLE_W = 16;
    localparam int FIR_W    = 32;

    // Coefficient table (Q1.15); taps past the table weigh zero
    localparam int COEF_COUNT = 31;
    localparam int COEF_IDX_W = $clog2(COEF_COUNT);
    localparam int TAP_IDX_W  = 7;

    localparam logic signed [15:0] COEF_Q15 [COEF_COUNT] = '{
        -16'sd40,   -16'sd58,   -16'sd62,   -16'sd28,   16'sd43,    16'sd125,
        16'sd181,   16'sd154,   16'sd0,     -16'sd261,  -16'sd541,  -16'sd720,
        -16'sd652,  -16'sd217,  16'sd499,   16'sd1443,  16'sd2470,  16'sd3361,
        16'sd3923,  16'sd4033,  16'sd3679,  16'sd2930,  16'sd1903,  16'sd776,
        -16'sd225,  -16'sd799,  -16'sd770,  -16'sd119,  16'sd1008,  16'sd2281,
        16'sd3219
    };

    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;
    localparam logic [16:0] GAIN_ONE  = 17'd32768;

    localparam longint unsigned HALF_PI_Q28 = 64'd421657428;

    // Register map
    localparam int REG_IDX_W  = 2;
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_NOISE_GAIN    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MOD_DEPTH     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_AM_PHASE_STEP = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_SEED    = 2'd3;

    localparam logic [15:0] RST_NOISE_GAIN    = 16'd26214;
    localparam logic [15:0] RST_MOD_DEPTH     = 16'd29491;
    localparam logic [31:0] RST_AM_PHASE_STEP = 32'd4740582;
    localparam logic [31:0] RST_NOISE_SEED    = 32'd1;

    typedef struct packed {
        logic [15:0] noise_gain;
        logic [15:0] mod_depth;
        logic [31:0] am_phase_step;
        logic        seed_load;
        logic [31:0] seed_value;
    } fdnam_cfg_t;

    typedef struct packed {
        logic write;
        logic start;
        logic rd_en;
        logic mul_g;
        logic mul_n;
        logic mix;
        logic rnd;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic load_out;
    } fdnam_cmd_t;

    typedef struct packed {
        logic last_tap;
    } fdnam_status_t;

    function automatic logic signed [15:0] coef_at(input logic [TAP_IDX_W-1:0] t);
        logic signed [15:0] c;
        c = '0;
        if (t < TAP_IDX_W'(COEF_COUNT))
            c = COEF_Q15[t[COEF_IDX_W-1:0]];
        return c;
    endfunction

    // One sine entry in Q15: quadrant fold, Taylor series through x^13 in Q28
    function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                       input int unsigned bits);
        longint unsigned n;
        longint unsigned quarter;
        longint unsigned kk;
        longint unsigned q;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned res;
        longint          sum;
        int unsigned     i;
        logic signed [15:0] mag;
        n       = 64'd1 << bits;
        quarter = n >> 2;
        kk      = longint'(k) & (n - 64'd1);
        q       = kk >> (bits - 2);
        r       = kk & (quarter - 64'd1);
        if ((q & 64'd1) != 64'd0)
            r = quarter - r;
        x    = (r * HALF_PI_Q28) >> (bits - 2);
        x2   = (x * x) >> 28;
        term = x;
        sum  = longint'(x);
        for (i = 1; i <= 6; i++) begin
            term = (term * x2) >> 28;
            case (i)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                default: term = term / 64'd156;
            endcase
            if ((i & 1) != 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        res = (longint'(sum) + 64'd4096) >> 13;
        if (res > 64'd32767)
            res = 64'd32767;
        mag = 16'(res);
        return (q >= 64'd2) ? -mag : mag;
    endfunction

endpackage

### hw/rtl/fir_decimator_noise_am_mixer_core.sv
// ----------------------------------------------------------------------------
// fir_decimator_noise_am_mixer_core
// Decimating FIR with LFSR noise mixing and sine amplitude modulation.
// ----------------------------------------------------------------------------
// Input samples arrive on sample/in_valid/in_ready; every transaction writes
// the sample into the delay line. The first sample of each group of
// DECIMATION produces one result on out_sample/out_valid/out_ready.
// Registers (noise gain, modulation depth, phase step, noise seed) sit on the
// APB port at byte addresses 0, 4, 8 and 12; write them only while idle.
// A sample that produces no result leaves in_ready high. A group-head
// sample holds in_ready low while the taps are walked, one tap per cycle
// through the single shared multiply-accumulate, then through ten steps
// of pipeline drain, mixing, modulation and rounding. out_valid rises at
// the same edge at which in_ready returns.
// The result waits in an output register; further samples are taken while
// it waits, and the sequencer only holds before loading the next result.
// Reset clears the delay line (through per-entry written flags), positions
// and phase, seeds the noise generator with one and loads register defaults.
// ----------------------------------------------------------------------------
module fir_decimator_noise_am_mixer_core
#(
    parameter int TAPS            = fdnam_pkg::DEF_TAPS,
    parameter int DECIMATION      = fdnam_pkg::DEF_DECIMATION,
    parameter int SINE_TABLE_BITS = fdnam_pkg::DEF_SINE_TABLE_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fdnam_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic signed [fdnam_pkg::SAMPLE_W-1:0] sample,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    output logic signed [fdnam_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready
);

    fdnam_pkg::fdnam_cfg_t    cfg;
    fdnam_pkg::fdnam_cmd_t    cmd;
    fdnam_pkg::fdnam_status_t status;

    fdnam_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fdnam_ctrl
    #(
        .DECIMATION (DECIMATION)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    fdnam_datapath
    #(
        .TAPS            (TAPS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg        (cfg),
        .sample     (sample),
        .out_sample (out_sample)
    );

endmodule

### hw/rtl/fdnam_regs.sv
// ----------------------------------------------------------------------------
// fdnam_regs
// APB register file: noise gain, modulation depth, phase step and noise seed.
// ----------------------------------------------------------------------------
module fdnam_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fdnam_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output fdnam_pkg::fdnam_cfg_t            cfg
);

    logic [15:0] gain_reg;
    logic [15:0] depth_reg;
    logic [31:0] step_reg;
    logic [31:0] seed_reg;
    logic        wr_en;
    logic [fdnam_pkg::REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[fdnam_pkg::APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= fdnam_pkg::RST_NOISE_GAIN;
            depth_reg <= fdnam_pkg::RST_MOD_DEPTH;
            step_reg  <= fdnam_pkg::RST_AM_PHASE_STEP;
            seed_reg  <= fdnam_pkg::RST_NOISE_SEED;
        end
        else if (wr_en)
        begin
            case (idx)
                fdnam_pkg::REG_NOISE_GAIN:    gain_reg  <= pwdata[15:0];
                fdnam_pkg::REG_MOD_DEPTH:     depth_reg <= pwdata[15:0];
                fdnam_pkg::REG_AM_PHASE_STEP: step_reg  <= pwdata;
                fdnam_pkg::REG_NOISE_SEED:    seed_reg  <= pwdata;
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            fdnam_pkg::REG_NOISE_GAIN:    prdata = {16'd0, gain_reg};
            fdnam_pkg::REG_MOD_DEPTH:     prdata = {16'd0, depth_reg};
            fdnam_pkg::REG_AM_PHASE_STEP: prdata = step_reg;
            fdnam_pkg::REG_NOISE_SEED:    prdata = seed_reg;
            default:                      prdata = '0;
        endcase
    end

    // Seed loads the noise generator at the write edge itself
    always_comb
    begin
        cfg.noise_gain    = gain_reg;
        cfg.mod_depth     = depth_reg;
        cfg.am_phase_step = step_reg;
        cfg.seed_load     = wr_en && (idx == fdnam_pkg::REG_NOISE_SEED);
        cfg.seed_value    = pwdata;
    end

endmodule

### hw/rtl/fdnam_datapath.sv
// ----------------------------------------------------------------------------
// fdnam_datapath
// Delay line, tap MAC, noise generator, mixer, AM stage and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdnam_datapath
#(
    parameter int TAPS            = fdnam_pkg::DEF_TAPS,
    parameter int SINE_TABLE_BITS = fdnam_pkg::DEF_SINE_TABLE_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  fdnam_pkg::fdnam_cmd_t               cmd,
    output fdnam_pkg::fdnam_status_t            status,
    input  fdnam_pkg::fdnam_cfg_t               cfg,
    input  logic signed [fdnam_pkg::SAMPLE_W-1:0] sample,
    output logic signed [fdnam_pkg::SAMPLE_W-1:0] out_sample
);

    localparam int TAP_W    = $clog2(TAPS);
    localparam int SINE_N   = 1 << SINE_TABLE_BITS;
    localparam int FIR_W    = fdnam_pkg::FIR_W;
    localparam int P1_W     = FIR_W + 18;
    localparam int P2_W     = 34;
    localparam int MIX_W    = P1_W;
    localparam int MIX15_W  = MIX_W - 15;
    localparam int HI_W     = MIX15_W - 16;
    localparam int DS_W     = 34;
    localparam int F_W      = 19;
    localparam int PLO_W    = 17 + F_W;
    localparam int PHI_W    = HI_W + F_W;
    localparam int PROD_W   = PHI_W + 16;

    localparam logic [TAP_W-1:0] LAST_POS = TAP_W'(TAPS - 1);

    localparam logic signed [MIX_W-1:0]   R14_MIX   = MIX_W'(1 << 14);
    localparam logic signed [MIX15_W-1:0] R14_MIX15 = MIX15_W'(1 << 14);
    localparam logic signed [DS_W-1:0]    R14_DS    = DS_W'(1 << 14);
    localparam logic signed [PROD_W-1:0]  R29_PROD  = PROD_W'(1 << 29);
    localparam logic signed [F_W-1:0]     F_ONE     = F_W'(32768);
    localparam logic signed [PROD_W-1:0]  SAT_MAX   = PROD_W'(32767);
    localparam logic signed [PROD_W-1:0]  SAT_MIN   = -PROD_W'(32768);

    // Delay line storage and its written flags
    logic signed [15:0] delay_mem [TAPS];
    logic [TAPS-1:0]    vld_reg;

    logic [TAP_W-1:0] wr_pos_reg;
    logic [TAP_W-1:0] rd_ptr_reg;
    logic [TAP_W-1:0] tap_reg;
    logic             s1_v_reg;
    logic             s2_v_reg;
    logic [31:0]      lfsr_reg;
    logic [31:0]      lfsr_step;
    logic [31:0]      phase_reg;

    logic signed [15:0]        rd_data_reg;
    logic                      rd_ok_reg;
    logic signed [15:0]        coef_reg;
    logic signed [31:0]        prod_reg;
    logic signed [FIR_W-1:0]   acc_reg;
    logic signed [15:0]        sine_reg;
    logic signed [P1_W-1:0]    p1_reg;
    logic signed [P2_W-1:0]    p2_reg;
    logic signed [MIX_W-1:0]   mix30_reg;
    logic signed [MIX15_W-1:0] mix15_reg;
    logic signed [DS_W-1:0]    ds_reg;
    logic signed [F_W-1:0]     f_reg;
    logic signed [PLO_W-1:0]   plo_reg;
    logic signed [PHI_W-1:0]   phi_reg;
    logic signed [PROD_W-1:0]  mprod_reg;
    logic signed [15:0]        out_sample_reg;

    logic [16:0]           g_sat;
    logic [16:0]           d_sat;
    logic [16:0]           sig_gain;
    logic                  mod_on;
    logic signed [15:0]    tap_sample;
    logic signed [15:0]    noise;
    logic signed [PROD_W-1:0] y_full;
    logic signed [PROD_W-1:0] y_sat;

    logic signed [15:0] sine_rom [SINE_N];

    for (genvar k = 0; k < SINE_N; k++) begin : g_sine
        localparam logic signed [15:0] SINE_VAL =
            fdnam_pkg::sine_entry(k, SINE_TABLE_BITS);
        assign sine_rom[k] = SINE_VAL;
    end

    assign g_sat    = (cfg.noise_gain > 16'd32768) ? fdnam_pkg::GAIN_ONE
                                                   : {1'b0, cfg.noise_gain};
    assign d_sat    = (cfg.mod_depth > 16'd32768) ? fdnam_pkg::GAIN_ONE
                                                  : {1'b0, cfg.mod_depth};
    assign sig_gain = fdnam_pkg::GAIN_ONE - g_sat;
    assign mod_on   = (cfg.mod_depth != 16'd0) && (cfg.am_phase_step != 32'd0);

    assign lfsr_step  = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ fdnam_pkg::LFSR_MASK)
                                    : (lfsr_reg >> 1);
    assign noise      = $signed(lfsr_reg[31:16]);
    assign tap_sample = rd_ok_reg ? rd_data_reg : 16'sd0;

    assign status.last_tap = (tap_reg == LAST_POS);

    // Control state: pointers, flags, noise generator and phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            wr_pos_reg <= '0;
            rd_ptr_reg <= '0;
            tap_reg    <= '0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            lfsr_reg   <= 32'd1;
            phase_reg  <= '0;
        end
        else
        begin
            s1_v_reg <= cmd.rd_en;
            s2_v_reg <= s1_v_reg;
            if (cmd.write)
            begin
                vld_reg[wr_pos_reg] <= 1'b1;
                wr_pos_reg <= (wr_pos_reg == LAST_POS) ? '0 : wr_pos_reg + 1'b1;
            end
            if (cmd.start)
            begin
                rd_ptr_reg <= wr_pos_reg;
                tap_reg    <= '0;
            end
            else if (cmd.rd_en)
            begin
                // walk backwards from the newest sample
                rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_POS : rd_ptr_reg - 1'b1;
                tap_reg    <= tap_reg + 1'b1;
            end
            if (cfg.seed_load)
                lfsr_reg <= (cfg.seed_value == 32'd0) ? 32'd1 : cfg.seed_value;
            else if (cmd.start)
                lfsr_reg <= lfsr_step;
            if (cmd.load_out && mod_on)
                phase_reg <= phase_reg + cfg.am_phase_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write)
            delay_mem[wr_pos_reg] <= sample;
        if (cmd.rd_en)
        begin
            rd_data_reg <= delay_mem[rd_ptr_reg];
            rd_ok_reg   <= vld_reg[rd_ptr_reg];
            coef_reg    <= fdnam_pkg::coef_at(fdnam_pkg::TAP_IDX_W'(tap_reg));
        end
    end

    // Arithmetic pipeline: tap product and accumulator, then the mixing and AM steps
    always_ff @(posedge clk)
    begin
        prod_reg <= coef_reg * tap_sample;
        if (cmd.start)
            acc_reg <= '0;
        else if (s2_v_reg)
            acc_reg <= acc_reg + prod_reg;
        if (cmd.mul_g)
        begin
            p1_reg   <= acc_reg * $signed({1'b0, sig_gain});
            sine_reg <= sine_rom[phase_reg[31 -: SINE_TABLE_BITS]];
        end
        if (cmd.mul_n)
        begin
            p2_reg <= noise * $signed({1'b0, g_sat});
            ds_reg <= $signed({1'b0, d_sat}) * sine_reg;
        end
        if (cmd.mix)
        begin
            mix30_reg <= p1_reg + (MIX_W'(p2_reg) <<< 15);
            f_reg     <= F_ONE + F_W'((ds_reg + R14_DS) >>> 15);
        end
        if (cmd.rnd)
            mix15_reg <= MIX15_W'((mix30_reg + R14_MIX) >>> 15);
        if (cmd.mul_lo)
            plo_reg <= $signed({1'b0, mix15_reg[15:0]}) * f_reg;
        if (cmd.mul_hi)
            phi_reg <= $signed(mix15_reg[MIX15_W-1:16]) * f_reg;
        if (cmd.sum)
            mprod_reg <= (PROD_W'(phi_reg) <<< 16) + PROD_W'(plo_reg);
        if (cmd.load_out)
            out_sample_reg <= 16'(y_sat);
    end

    always_comb
    begin
        if (mod_on)
            y_full = (mprod_reg + R29_PROD) >>> 30;
        else
            y_full = PROD_W'((mix15_reg + R14_MIX15) >>> 15);
        if (y_full > SAT_MAX)
            y_sat = SAT_MAX;
        else if (y_full < SAT_MIN)
            y_sat = SAT_MIN;
        else
            y_sat = y_full;
    end

    assign out_sample = out_sample_reg;

    `FDNAM_ASSERT_NEVER(a_wr_pos_range, wr_pos_reg > LAST_POS, "write position past delay line")
    `FDNAM_ASSERT_NEVER(a_rd_ptr_range, rd_ptr_reg > LAST_POS, "read pointer past delay line")
    `FDNAM_ASSERT(a_acc_cleared, cmd.start |=> (acc_reg == '0), "accumulator not cleared")

endmodule

### hw/rtl/fdnam_ctrl.sv
// ----------------------------------------------------------------------------
// fdnam_ctrl
// Sequencer: decimation count, tap walk, arithmetic steps and output valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdnam_ctrl
#(
    parameter int DECIMATION = fdnam_pkg::DEF_DECIMATION
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    input  fdnam_pkg::fdnam_status_t status,
    output fdnam_pkg::fdnam_cmd_t    cmd
);

    localparam int DEC_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam logic [DEC_W-1:0] LAST_DEC = DEC_W'(DECIMATION - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MAC    = 4'd1;
    localparam logic [3:0] S_DRAIN0 = 4'd2;
    localparam logic [3:0] S_DRAIN1 = 4'd3;
    localparam logic [3:0] S_MULG   = 4'd4;
    localparam logic [3:0] S_MULN   = 4'd5;
    localparam logic [3:0] S_MIX    = 4'd6;
    localparam logic [3:0] S_RND    = 4'd7;
    localparam logic [3:0] S_MULLO  = 4'd8;
    localparam logic [3:0] S_MULHI  = 4'd9;
    localparam logic [3:0] S_SUM    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [DEC_W-1:0] dec_reg;
    logic [DEC_W-1:0] dec_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        dec_next       = dec_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.write      = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dec_next = (dec_reg == LAST_DEC) ? '0 : dec_reg + 1'b1;
                    if (dec_reg == '0)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                cmd.rd_en = 1'b1;
                if (status.last_tap)
                    state_next = S_DRAIN0;
            end
            // let the last products reach the accumulator
            S_DRAIN0: state_next = S_DRAIN1;
            S_DRAIN1: state_next = S_MULG;
            S_MULG:
            begin
                cmd.mul_g  = 1'b1;
                state_next = S_MULN;
            end
            S_MULN:
            begin
                cmd.mul_n  = 1'b1;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = S_RND;
            end
            S_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = S_MULLO;
            end
            S_MULLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MULHI;
            end
            S_MULHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dec_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dec_reg       <= dec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FDNAM_ASSERT(a_start_to_mac, cmd.start |=> (state_reg == S_MAC), "group head did not start MAC")
    `FDNAM_ASSERT(a_load_has_room, cmd.load_out |-> (!out_valid_reg || out_ready), "output overwritten")
    `FDNAM_ASSERT_NEVER(a_dec_range, dec_reg > LAST_DEC, "decimation count out of range")

endmodule
